// ===== rtl/tak_pkg.sv =====
// Shared types, constants and helpers for the tilt angle Kalman filter.
// No dependencies; tak_div and the top level import this package.
`default_nettype none
package tak_pkg;

  localparam int TIME_FRAC = 16;
  localparam int GAIN_FRAC = 30;

  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 2'd2;

  localparam logic [CFG_W-1:0] ANGLE_NOISE_RST = 31'd268435;
  localparam logic [CFG_W-1:0] BIAS_NOISE_RST  = 31'd805306;
  localparam logic [CFG_W-1:0] MEAS_NOISE_RST  = 31'd8053064;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    OP_PRED_ANGLE = 4'd0,
    OP_PRED_AA1   = 4'd1,
    OP_PRED_AA2   = 4'd2,
    OP_PRED_AB    = 4'd3,
    OP_PRED_BB    = 4'd4,
    OP_CORR_ANGLE = 4'd5,
    OP_CORR_BIAS  = 4'd6,
    OP_UPD_AA     = 4'd7,
    OP_UPD_AB     = 4'd8,
    OP_UPD_BA     = 4'd9,
    OP_UPD_BB     = 4'd10
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL    = 5'b00010,
    ST_POST   = 5'b00100,
    ST_DSTART = 5'b01000,
    ST_DWAIT  = 5'b10000
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) r = S32_MAX;
    else if (v < -40'sd2147483648) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tak_if.sv =====
// Valid/ready channel interfaces for filter samples and results.
// Depends on nothing.
`default_nettype none
interface tak_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] measured_angle;
  logic signed [31:0] turn_rate;
  logic [15:0]        elapsed_time;
  modport source(output valid, measured_angle, turn_rate, elapsed_time, input ready);
  modport sink(input valid, measured_angle, turn_rate, elapsed_time, output ready);
endinterface

interface tak_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle_estimate;
  logic signed [31:0] rate_bias;
  modport source(output valid, angle_estimate, rate_bias, input ready);
  modport sink(input valid, angle_estimate, rate_bias, output ready);
endinterface
`default_nettype wire

// ===== rtl/tak_mul.sv =====
// Shared signed 33x33 multiplier with a registered product.
// Depends on nothing.
`default_nettype none
module tak_mul (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire logic signed [32:0] a,
  input  wire logic signed [32:0] b,
  output logic signed [65:0]      prod
);

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= a * b;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/tak_div.sv =====
// Restoring divider for the Kalman gains: sat32((num * 2^30) / den), den > 0.
// One quotient bit per cycle; depends on tak_pkg.
`default_nettype none
module tak_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic [31:0]        den,
  output logic                    done,
  output logic signed [31:0]      quo
);
  import tak_pkg::*;

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] lo;
  logic [31:0] q;
  logic        neg;

  logic [31:0] mag;
  logic [31:0] hi;
  logic [32:0] rem2;
  logic        ge;
  logic [32:0] diff;
  logic [31:0] q_next;

  assign mag    = num[31] ? 32'(-num) : 32'(num);
  assign hi     = {2'b00, mag[31:2]};
  assign rem2   = {rem, lo[31]};
  assign ge     = rem2 >= {1'b0, den};
  assign diff   = rem2 - {1'b0, den};
  assign q_next = {q[30:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg <= num[31];
        if (hi >= den) begin
          // quotient needs more than 32 bits: saturate at once
          quo  <= num[31] ? S32_MIN : S32_MAX;
          done <= 1'b1;
        end else begin
          rem  <= hi;
          lo   <= {mag[1:0], 30'd0};
          cnt  <= 5'd31;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= ge ? diff[31:0] : rem2[31:0];
        lo  <= {lo[30:0], 1'b0};
        q   <= q_next;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (!neg) quo <= q_next[31] ? S32_MAX : q_next;
          else quo <= (q_next > 32'h8000_0000) ? S32_MIN : 32'(-q_next);
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt == 5'd0) |=> (done && !busy))
    else $error("divider did not finish after last step");
`endif
endmodule
`default_nettype wire

// ===== rtl/tilt_angle_kalman_filter.sv =====
// Two-state (angle, gyro bias) Kalman filter, top level and sequencer.
// Depends on tak_pkg, tak_if, tak_mul and tak_div.
//
// Usage:
//   sample_in  carries measured_angle (Q16.16), turn_rate (Q16.16) and
//   elapsed_time (Q0.16 s). result_out carries angle_estimate and rate_bias
//   (Q16.16). One result item per sample item, in order.
//   The cfg port writes the noise registers (index 0 angle, 1 bias,
//   2 measurement); write them only while the filter is idle.
// Sequencing:
//   One sample takes 11 multiply steps on one shared multiplier, plus two
//   gain divisions on a bit-serial divider (a division ends early when the
//   gain saturates and is skipped with a zero gain when the innovation
//   variance is not positive). sample_in is ready again from the edge that
//   loads the result, so a new sample is not accepted before then.
// Reset clears state estimate and covariance to zero and loads the default
// noise values. A stalled receiver holds the result in the output register;
// the next sample is still taken and processed, and its result waits until
// the held one is taken.
`default_nettype none
module tilt_angle_kalman_filter (
  input  wire logic                          clk,
  input  wire logic                          rst,
  tak_in_if.sink                             sample_in,
  tak_out_if.source                          result_out,
  input  wire logic                          cfg_we,
  input  wire logic [tak_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tak_pkg::CFG_W-1:0]     cfg_data
);
  import tak_pkg::*;

  state_t state;
  op_t    op;
  logic   div_sel;

  logic [CFG_W-1:0] angle_noise, bias_noise, meas_noise;

  logic signed [31:0] ang, bias, c00, c01, c10, c11;
  logic signed [31:0] p00, p01, p10, p11;
  logic signed [31:0] meas, rate, k0, k1, y;
  logic [15:0]        dt;
  logic signed [39:0] acc;

  logic                  out_valid;
  logic signed [31:0]    out_angle, out_bias;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [65:0] rs_time, rs_gain;
  logic signed [39:0] rnd, base, sum, sum_b, y_wide;
  logic               use_time, sub;
  logic signed [32:0] s;
  logic               s_pos;
  logic               div_start, div_done;
  logic signed [31:0] div_quo;
  logic               in_fire, out_free, load_out;

  function automatic logic signed [39:0] ext40(input logic signed [31:0] v);
    return {{8{v[31]}}, v};
  endfunction

  assign sample_in.ready       = (state == ST_IDLE);
  assign in_fire               = sample_in.valid && sample_in.ready;
  assign result_out.valid      = out_valid;
  assign result_out.angle_estimate = out_angle;
  assign result_out.rate_bias  = out_bias;
  assign out_free              = !out_valid || result_out.ready;
  assign load_out              = (state == ST_POST) && (op == OP_UPD_BB) && out_free;

  // multiplier operand selection
  always_comb begin
    mul_a = {{17{1'b0}}, dt};
    mul_b = '0;
    case (op)
      OP_PRED_ANGLE: mul_b = {rate[31], rate} - {bias[31], bias};
      OP_PRED_AA1:   mul_b = {c10[31], c10} + {c01[31], c01};
      OP_PRED_AA2:   mul_b = {2'b00, angle_noise};
      OP_PRED_AB:    mul_b = {c11[31], c11};
      OP_PRED_BB:    mul_b = {2'b00, bias_noise};
      OP_CORR_ANGLE: begin mul_a = {k0[31], k0}; mul_b = {y[31], y}; end
      OP_CORR_BIAS:  begin mul_a = {k1[31], k1}; mul_b = {y[31], y}; end
      OP_UPD_AA:     begin mul_a = {k0[31], k0}; mul_b = {p00[31], p00}; end
      OP_UPD_AB:     begin mul_a = {k0[31], k0}; mul_b = {p01[31], p01}; end
      OP_UPD_BA:     begin mul_a = {k1[31], k1}; mul_b = {p00[31], p00}; end
      OP_UPD_BB:     begin mul_a = {k1[31], k1}; mul_b = {p01[31], p01}; end
      default:       mul_b = '0;
    endcase
  end

  tak_mul u_mul (
    .clk  (clk),
    .load (state == ST_MUL),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // round to nearest, ties up, then add or subtract into the base value
  assign rs_time  = (prod + (66'sd1 <<< (TIME_FRAC - 1))) >>> TIME_FRAC;
  assign rs_gain  = (prod + (66'sd1 <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
  assign use_time = (op == OP_PRED_ANGLE) || (op == OP_PRED_AA1) || (op == OP_PRED_AA2) ||
                    (op == OP_PRED_AB) || (op == OP_PRED_BB);
  assign rnd      = use_time ? rs_time[39:0] : rs_gain[39:0];

  always_comb begin
    base = ext40(ang);
    sub  = 1'b0;
    case (op)
      OP_PRED_ANGLE: base = ext40(ang);
      OP_PRED_AA1:   begin base = ext40(c00); sub = 1'b1; end
      OP_PRED_AA2:   base = acc;
      OP_PRED_AB:    begin base = ext40(c01); sub = 1'b1; end
      OP_PRED_BB:    base = ext40(c11);
      OP_CORR_ANGLE: base = ext40(ang);
      OP_CORR_BIAS:  base = ext40(bias);
      OP_UPD_AA:     begin base = ext40(p00); sub = 1'b1; end
      OP_UPD_AB:     begin base = ext40(p01); sub = 1'b1; end
      OP_UPD_BA:     begin base = ext40(p10); sub = 1'b1; end
      OP_UPD_BB:     begin base = ext40(p11); sub = 1'b1; end
      default:       base = ext40(ang);
    endcase
  end

  assign sum    = sub ? base - rnd : base + rnd;
  assign sum_b  = ext40(c10) - rnd;
  assign y_wide = ext40(meas) - ext40(ang);

  assign s         = {p00[31], p00} + {2'b00, meas_noise};
  assign s_pos     = !s[32] && (s != 33'sd0);
  assign div_start = (state == ST_DSTART) && s_pos;

  tak_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_sel ? p10 : p00),
    .den   (s[31:0]),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      op          <= OP_PRED_ANGLE;
      div_sel     <= 1'b0;
      out_valid   <= 1'b0;
      angle_noise <= ANGLE_NOISE_RST;
      bias_noise  <= BIAS_NOISE_RST;
      meas_noise  <= MEAS_NOISE_RST;
      ang         <= '0;
      bias        <= '0;
      c00         <= '0;
      c01         <= '0;
      c10         <= '0;
      c11         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ANGLE_NOISE: angle_noise <= cfg_data;
          CFG_BIAS_NOISE:  bias_noise  <= cfg_data;
          CFG_MEAS_NOISE:  meas_noise  <= cfg_data;
          default:         ;
        endcase
      end
      if (load_out) out_valid <= 1'b1;
      else if (result_out.ready) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            meas  <= sample_in.measured_angle;
            rate  <= sample_in.turn_rate;
            dt    <= sample_in.elapsed_time;
            op    <= OP_PRED_ANGLE;
            state <= ST_MUL;
          end
        end
        ST_MUL: state <= ST_POST;
        ST_POST: begin
          case (op)
            OP_PRED_ANGLE: ang <= sat32(sum);
            OP_PRED_AA1:   acc <= sum;
            OP_PRED_AA2:   p00 <= sat32(sum);
            OP_PRED_AB:    begin p01 <= sat32(sum); p10 <= sat32(sum_b); end
            OP_PRED_BB:    begin p11 <= sat32(sum); y <= sat32(y_wide); end
            OP_CORR_ANGLE: ang <= sat32(sum);
            OP_CORR_BIAS:  bias <= sat32(sum);
            OP_UPD_AA:     p00 <= sat32(sum);
            OP_UPD_AB:     p01 <= sat32(sum);
            OP_UPD_BA:     p10 <= sat32(sum);
            default:       ;
          endcase
          if (op == OP_PRED_BB) begin
            div_sel <= 1'b0;
            state   <= ST_DSTART;
          end else if (op == OP_UPD_BB) begin
            // hold the last step until the output register is free
            if (out_free) begin
              state     <= ST_IDLE;
              out_angle <= ang;
              out_bias  <= bias;
              c00       <= p00;
              c01       <= p01;
              c10       <= p10;
              c11       <= sat32(sum);
            end
          end else begin
            op    <= op_t'(op + 4'd1);
            state <= ST_MUL;
          end
        end
        ST_DSTART: begin
          if (s_pos) begin
            state <= ST_DWAIT;
          end else begin
            // variance not positive: zero gain
            if (div_sel) k1 <= '0;
            else k0 <= '0;
            if (!div_sel) begin
              div_sel <= 1'b1;
              state   <= ST_DSTART;
            end else begin
              op    <= OP_CORR_ANGLE;
              state <= ST_MUL;
            end
          end
        end
        ST_DWAIT: begin
          if (div_done) begin
            if (div_sel) k1 <= div_quo;
            else k0 <= div_quo;
            if (!div_sel) begin
              div_sel <= 1'b1;
              state   <= ST_DSTART;
            end else begin
              op    <= OP_CORR_ANGLE;
              state <= ST_MUL;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == ST_MUL && op == OP_PRED_ANGLE))
    else $error("accepted item did not start the prediction");
  a_div_only_pos: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (!s[32] && s != 33'sd0))
    else $error("division started with non-positive variance");
  a_result_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POST && op == OP_UPD_BB && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("finished item did not reach the output register");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DWAIT) |-> !sample_in.ready)
    else $error("ready while dividing");
`endif
endmodule
`default_nettype wire
